FILE: design/biphase_backchannel_frame_decoder_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the biphase backchannel frame decoder
// Sampled on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef BIPHASE_BACKCHANNEL_FRAME_DECODER_ASSERT_SVH
`define BIPHASE_BACKCHANNEL_FRAME_DECODER_ASSERT_SVH

// same-cycle implication
`define BBFD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BBFD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/bbfd_pkg.sv
// ----------------------------------------------------------------------------
// bbfd_pkg
// Types, constants and half-bit / frame helpers for the frame decoder.
// ----------------------------------------------------------------------------
package bbfd_pkg;

	localparam int unsigned PREAMBLE_LEN    = 20;
	localparam int unsigned DATA_HALF_BITS  = 20;
	localparam int unsigned FRAME_HALF_BITS = PREAMBLE_LEN + DATA_HALF_BITS;
	localparam int unsigned POS_W           = $clog2(FRAME_HALF_BITS + 1);
	localparam int unsigned IDX_W           = $clog2(DATA_HALF_BITS);
	localparam int unsigned INTERVAL_W      = 16;
	localparam int unsigned CFG_W           = 16;
	localparam int unsigned CFG_IDX_W       = 2;
	localparam int unsigned FB_W            = 8;
	localparam int unsigned FB_BITS         = 9;   // select + feedback bits checked

	localparam int unsigned Q_DEPTH         = 2;
	localparam int unsigned Q_PTR_W         = $clog2(Q_DEPTH);
	localparam int unsigned Q_CNT_W         = $clog2(Q_DEPTH + 1);

	localparam logic [CFG_W-1:0] RST_MIN_INTERVAL  = 16'd125;
	localparam logic [CFG_W-1:0] RST_LONG_INTERVAL = 16'd375;
	localparam logic [CFG_W-1:0] RST_MAX_INTERVAL  = 16'd625;
	localparam logic [CFG_W-1:0] RST_DISC_LIMIT    = 16'd1000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MIN_INTERVAL     = 2'd0,
		CFG_LONG_INTERVAL    = 2'd1,
		CFG_MAX_INTERVAL     = 2'd2,
		CFG_DISCONNECT_LIMIT = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [CFG_W-1:0] min_interval;
		logic [CFG_W-1:0] long_interval;
		logic [CFG_W-1:0] max_interval;
		logic [CFG_W-1:0] disconnect_limit;
	} cfg_t;

	typedef struct packed {
		logic                  req_type;
		logic                  new_level;
		logic [INTERVAL_W-1:0] interval;
	} req_t;

	typedef struct packed {
		logic            frame_done;
		logic            link_connected;
		logic            data_valid;
		logic            power_select;
		logic [FB_W-1:0] power_feedback;
	} rsp_t;

	typedef enum logic [1:0] {
		OP_DROP = 2'd0,   // illegal interval, framing lost
		OP_ONE  = 2'd1,   // one half-bit
		OP_TWO  = 2'd2,   // two half-bits
		OP_TICK = 2'd3    // housekeeping tick
	} op_t;

	typedef struct packed {
		op_t  op;
		logic level;
	} cmd_t;

	typedef struct packed {
		logic [POS_W-1:0] pos;
		logic             wr;
		logic [IDX_W-1:0] idx;
		logic             done;
	} push_t;

	typedef struct packed {
		logic            ok;
		logic            sel;
		logic [FB_W-1:0] fb;
	} frame_t;

	// one half-bit into the framer
	function automatic push_t push_half_bit(logic [POS_W-1:0] pos, logic level);
		push_t            r;
		logic [POS_W-1:0] nxt;
		r.wr   = 1'b0;
		r.idx  = '0;
		r.done = 1'b0;
		if (pos < POS_W'(PREAMBLE_LEN)) begin
			// preamble alternates 0,1,... so the expected level is the position LSB
			nxt = (pos[0] == level) ? pos + POS_W'(1) : '0;
		end else begin
			r.wr  = 1'b1;
			r.idx = IDX_W'(pos - POS_W'(PREAMBLE_LEN));
			nxt   = pos + POS_W'(1);
		end
		if (nxt >= POS_W'(FRAME_HALF_BITS)) begin
			r.done = 1'b1;
			nxt    = '0;
		end
		r.pos = nxt;
		return r;
	endfunction

	// differential bi-phase: transition required at every bit boundary
	function automatic frame_t decode_frame(logic [DATA_HALF_BITS-1:0] h);
		frame_t r;
		r.ok = 1'b1;
		for (int i = 0; i < FB_BITS; i++) begin
			if (h[2*i+1] == h[2*i+2])
				r.ok = 1'b0;
		end
		for (int i = 1; i < FB_BITS; i++) begin
			r.fb[i-1] = h[2*i] ^ h[2*i+1];
		end
		r.sel = h[0] ^ h[1];
		return r;
	endfunction

endpackage

FILE: design/bbfd_cfg.sv
// ----------------------------------------------------------------------------
// bbfd_cfg
// Configuration register file: interval window and disconnect limit.
// ----------------------------------------------------------------------------
module bbfd_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [bbfd_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [bbfd_pkg::CFG_W-1:0]      cfg_wdata,
	output bbfd_pkg::cfg_t                  cfg
);

	bbfd_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_interval     <= bbfd_pkg::RST_MIN_INTERVAL;
			cfg_q.long_interval    <= bbfd_pkg::RST_LONG_INTERVAL;
			cfg_q.max_interval     <= bbfd_pkg::RST_MAX_INTERVAL;
			cfg_q.disconnect_limit <= bbfd_pkg::RST_DISC_LIMIT;
		end else if (cfg_we) begin
			case (bbfd_pkg::cfg_reg_t'(cfg_idx))
				bbfd_pkg::CFG_MIN_INTERVAL:     cfg_q.min_interval     <= cfg_wdata;
				bbfd_pkg::CFG_LONG_INTERVAL:    cfg_q.long_interval    <= cfg_wdata;
				bbfd_pkg::CFG_MAX_INTERVAL:     cfg_q.max_interval     <= cfg_wdata;
				bbfd_pkg::CFG_DISCONNECT_LIMIT: cfg_q.disconnect_limit <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: design/bbfd_front.sv
// ----------------------------------------------------------------------------
// bbfd_front
// Accepts request words, classifies the flip interval and queues commands.
// ----------------------------------------------------------------------------
module bbfd_front (
	input  logic                clk,
	input  logic                arst_n,
	input  bbfd_pkg::cfg_t      cfg,
	input  logic                push,
	output logic                full,
	input  bbfd_pkg::req_t      din,
	output logic                cmd_vld,
	output bbfd_pkg::cmd_t      cmd,
	input  logic                cmd_pop
);

	bbfd_pkg::cmd_t                 cls;
	bbfd_pkg::cmd_t                 q_mem_q [bbfd_pkg::Q_DEPTH];
	logic [bbfd_pkg::Q_PTR_W-1:0]   wr_ptr_q;
	logic [bbfd_pkg::Q_PTR_W-1:0]   rd_ptr_q;
	logic [bbfd_pkg::Q_CNT_W-1:0]   cnt_q;
	logic                           wr_en;
	logic                           rd_en;

	always_comb begin
		cls.level = din.new_level;
		if (din.req_type)
			cls.op = bbfd_pkg::OP_TICK;
		else if (din.interval < cfg.min_interval || din.interval > cfg.max_interval)
			cls.op = bbfd_pkg::OP_DROP;
		else if (din.interval < cfg.long_interval)
			cls.op = bbfd_pkg::OP_ONE;
		else
			cls.op = bbfd_pkg::OP_TWO;
	end

	assign full    = (cnt_q == bbfd_pkg::Q_CNT_W'(bbfd_pkg::Q_DEPTH));
	assign cmd_vld = (cnt_q != '0);
	assign wr_en   = push && !full;
	assign rd_en   = cmd_pop && cmd_vld;
	assign cmd     = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en)
			q_mem_q[wr_ptr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en)
				wr_ptr_q <= wr_ptr_q + bbfd_pkg::Q_PTR_W'(1);
			if (rd_en)
				rd_ptr_q <= rd_ptr_q + bbfd_pkg::Q_PTR_W'(1);
			if (wr_en && !rd_en)
				cnt_q <= cnt_q + bbfd_pkg::Q_CNT_W'(1);
			else if (rd_en && !wr_en)
				cnt_q <= cnt_q - bbfd_pkg::Q_CNT_W'(1);
		end
	end

endmodule

FILE: design/bbfd_back.sv
// ----------------------------------------------------------------------------
// bbfd_back
// Framer, frame decode and link supervision; queues one result per command.
// ----------------------------------------------------------------------------
module bbfd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  bbfd_pkg::cfg_t      cfg,
	input  logic                cmd_vld,
	input  bbfd_pkg::cmd_t      cmd,
	output logic                cmd_pop,
	input  logic                pop,
	output logic                empty,
	output bbfd_pkg::rsp_t      dout
);

	logic [bbfd_pkg::POS_W-1:0]          pos_q, pos_n;
	logic [bbfd_pkg::DATA_HALF_BITS-1:0] store_q, store_n, store_1, store_2;
	logic [bbfd_pkg::CFG_W-1:0]          silence_q, silence_n;
	logic                                conn_q, conn_n;
	logic                                valid_q, valid_n;
	logic                                sel_q, sel_n;
	logic [bbfd_pkg::FB_W-1:0]           fb_q, fb_n;
	logic                                done;
	bbfd_pkg::push_t                     p1, p2;
	bbfd_pkg::frame_t                    frm;
	bbfd_pkg::rsp_t                      rsp;

	bbfd_pkg::rsp_t                      q_mem_q [bbfd_pkg::Q_DEPTH];
	logic [bbfd_pkg::Q_PTR_W-1:0]        wr_ptr_q;
	logic [bbfd_pkg::Q_PTR_W-1:0]        rd_ptr_q;
	logic [bbfd_pkg::Q_CNT_W-1:0]        cnt_q;
	logic                                res_full;
	logic                                fire;
	logic                                rd_en;

	// a long interval pushes the same level twice, chained combinationally
	always_comb begin
		p1      = bbfd_pkg::push_half_bit(pos_q, cmd.level);
		store_1 = store_q;
		if (p1.wr)
			store_1[p1.idx] = cmd.level;
		p2      = bbfd_pkg::push_half_bit(p1.pos, cmd.level);
		store_2 = store_1;
		if (p2.wr)
			store_2[p2.idx] = cmd.level;
	end

	always_comb begin
		pos_n     = pos_q;
		store_n   = store_q;
		silence_n = silence_q;
		conn_n    = conn_q;
		valid_n   = valid_q;
		sel_n     = sel_q;
		fb_n      = fb_q;
		done      = 1'b0;
		case (cmd.op)
			bbfd_pkg::OP_DROP: begin
				pos_n = '0;
			end
			bbfd_pkg::OP_ONE: begin
				pos_n   = p1.pos;
				store_n = store_1;
				done    = p1.done;
			end
			bbfd_pkg::OP_TWO: begin
				pos_n   = p2.pos;
				store_n = store_2;
				done    = p1.done || p2.done;
			end
			bbfd_pkg::OP_TICK: begin
				if (silence_q < cfg.disconnect_limit) begin
					silence_n = silence_q + bbfd_pkg::CFG_W'(1);
					if (silence_n == cfg.disconnect_limit) begin
						conn_n  = 1'b0;
						valid_n = 1'b0;
					end
				end
			end
			default: ;
		endcase
		// the store holds both writes; a second push never writes after a completion
		frm = bbfd_pkg::decode_frame(store_n);
		if (done) begin
			silence_n = '0;
			conn_n    = 1'b1;
			valid_n   = frm.ok;
			if (frm.ok) begin
				sel_n = frm.sel;
				fb_n  = frm.fb;
			end
		end
		rsp.frame_done     = done;
		rsp.link_connected = conn_n;
		rsp.data_valid     = valid_n;
		rsp.power_select   = sel_n;
		rsp.power_feedback = fb_n;
	end

	assign res_full = (cnt_q == bbfd_pkg::Q_CNT_W'(bbfd_pkg::Q_DEPTH));
	assign fire     = cmd_vld && !res_full;
	assign cmd_pop  = fire;
	assign empty    = (cnt_q == '0);
	assign rd_en    = pop && !empty;
	assign dout     = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (fire) begin
			store_q           <= store_n;
			q_mem_q[wr_ptr_q] <= rsp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			silence_q <= '0;
			conn_q    <= 1'b0;
			valid_q   <= 1'b0;
			sel_q     <= 1'b0;
			fb_q      <= '0;
		end else if (fire) begin
			pos_q     <= pos_n;
			silence_q <= silence_n;
			conn_q    <= conn_n;
			valid_q   <= valid_n;
			sel_q     <= sel_n;
			fb_q      <= fb_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (fire)
				wr_ptr_q <= wr_ptr_q + bbfd_pkg::Q_PTR_W'(1);
			if (rd_en)
				rd_ptr_q <= rd_ptr_q + bbfd_pkg::Q_PTR_W'(1);
			if (fire && !rd_en)
				cnt_q <= cnt_q + bbfd_pkg::Q_CNT_W'(1);
			else if (rd_en && !fire)
				cnt_q <= cnt_q - bbfd_pkg::Q_CNT_W'(1);
		end
	end

endmodule

FILE: design/biphase_backchannel_frame_decoder.sv
// ----------------------------------------------------------------------------
// biphase_backchannel_frame_decoder
// Decodes differential bi-phase backchannel frames from flip-interval words.
// ----------------------------------------------------------------------------
// Each pushed word (a level flip with its interval, or a housekeeping tick)
// gives exactly one result word, in order. Sustained rate is one word per
// clock on both sides while neither side stalls; a result is registered
// first in a two-entry command queue by classification, then in a two-entry
// result queue by the framer's state update, which chains up to two
// half-bits and the frame check. Each side stalls on its own: full only
// rises after the command queue fills while results back up. Configuration
// writes are taken any cycle but must only be made while the block is idle.
// ----------------------------------------------------------------------------
`include "biphase_backchannel_frame_decoder_assert.svh"

module biphase_backchannel_frame_decoder (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [bbfd_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [bbfd_pkg::CFG_W-1:0]      cfg_wdata,
	input  logic                            push,
	output logic                            full,
	input  bbfd_pkg::req_t                  din,
	output logic                            empty,
	input  logic                            pop,
	output bbfd_pkg::rsp_t                  dout
);

	bbfd_pkg::cfg_t cfg;
	bbfd_pkg::cmd_t cmd;
	logic           cmd_vld;
	logic           cmd_pop;

	bbfd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	bbfd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.push    (push),
		.full    (full),
		.din     (din),
		.cmd_vld (cmd_vld),
		.cmd     (cmd),
		.cmd_pop (cmd_pop)
	);

	bbfd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.cmd_vld (cmd_vld),
		.cmd     (cmd),
		.cmd_pop (cmd_pop),
		.pop     (pop),
		.empty   (empty),
		.dout    (dout)
	);

	`BBFD_ASSERT_NXT(a_push_lands, push && !full, cmd_vld, "accepted word lost before back end")
	`BBFD_ASSERT_NXT(a_cmd_result, cmd_vld && cmd_pop, !empty, "executed command gave no result")
	`BBFD_ASSERT_IMP(a_done_conn, !empty && dout.frame_done, dout.link_connected, "frame done without link")
	`BBFD_ASSERT_IMP(a_valid_conn, !empty && dout.data_valid, dout.link_connected, "valid data without link")

endmodule
